/* rtl/core/waving_sketch_topk_counter_core_defines.svh */
// ----------------------------------------------------------------------------
// waving_sketch_topk_counter_core_defines
// Assertion macros for the waving sketch core.
// ----------------------------------------------------------------------------
`ifndef WAVING_SKETCH_TOPK_COUNTER_CORE_DEFINES_SVH
`define WAVING_SKETCH_TOPK_COUNTER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define WSTC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wstc same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define WSTC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wstc next-cycle check failed");

`endif

/* rtl/core/wstc_pkg.sv */
// ----------------------------------------------------------------------------
// wstc_pkg
// Types and default constants for the waving sketch counter core.
// ----------------------------------------------------------------------------
`default_nettype none

package wstc_pkg;

	localparam int ROWS_DEF       = 1024;
	localparam int SLOTS_DEF      = 8;
	localparam int COUNT_BITS_DEF = 32;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	// input word
	typedef struct packed {
		logic        action;
		logic [63:0] flow_key;
		logic [9:0]  bucket_row;
		logic        key_sign;
	} in_word_t;

	// result word
	typedef struct packed {
		logic        found;
		logic [31:0] flow_count;
	} out_word_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_MOD,
		ST_START,
		ST_SCAN,
		ST_DECIDE,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

/* rtl/core/wstc_chan_if.sv */
// ----------------------------------------------------------------------------
// wstc_chan_if
// Valid/ready channel carrying one word of a parameter type.
// ----------------------------------------------------------------------------
`default_nettype none

interface wstc_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/waving_sketch_topk_counter_core.sv */
// ----------------------------------------------------------------------------
// waving_sketch_topk_counter_core
// Heavy-flow sketch: per-row key slots plus a signed waving counter.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one word {action, flow_key, bucket_row, key_sign}; out_ch
//   returns one word {found, flow_count} for every accepted word.
//   Each word walks its row one slot per cycle through the slot RAM read
//   port: accept, row reduction (only when ROWS < 1024), one issue step,
//   up to SLOTS_PER_ROW scan steps, one replace/waving step on a full row,
//   one result step. Hits, and empty slots on an insert, end the scan early.
//   in_ch.ready is high only when the sequencer is idle. The result sits in
//   an output register, so the next word is accepted while it waits; if the
//   receiver still stalls when the next result is ready, the sequencer
//   holds in its result state.
//   After reset a clearing pass zeroes slot counts, flags and waving
//   counters, one slot per cycle, over all ROWS*SLOTS_PER_ROW slots (8192
//   at the defaults) before the first word is accepted.
// ----------------------------------------------------------------------------
`default_nettype none
`include "waving_sketch_topk_counter_core_defines.svh"

module waving_sketch_topk_counter_core #(
	parameter int ROWS          = wstc_pkg::ROWS_DEF,
	parameter int SLOTS_PER_ROW = wstc_pkg::SLOTS_DEF,
	parameter int COUNT_BITS    = wstc_pkg::COUNT_BITS_DEF
) (
	input wire logic     clk,
	input wire logic     arst_n,
	wstc_chan_if.sink    in_ch,
	wstc_chan_if.source  out_ch
);
	import wstc_pkg::*;

	localparam int NSLOTS = ROWS * SLOTS_PER_ROW;
	localparam int AW     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
	localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SW     = (SLOTS_PER_ROW > 1) ? $clog2(SLOTS_PER_ROW) : 1;
	localparam int MW     = COUNT_BITS + 2;
	localparam int CMPW   = (COUNT_BITS > 33) ? COUNT_BITS : 33;
	localparam bit NEED_MOD = (ROWS < 1024);
	localparam logic [CMPW-1:0] HALF_C = CMPW'(64'h8000_0000);
	localparam logic [CMPW-1:0] OUT_MAX_C = CMPW'(64'hFFFF_FFFF);
	localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS_PER_ROW - 1);

	function automatic logic [COUNT_BITS-1:0] cnt_inc(input logic [COUNT_BITS-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	function automatic logic [31:0] out_cnt(input logic [COUNT_BITS-1:0] c);
		logic [CMPW-1:0] ce;
		ce = CMPW'(c);
		return (ce > OUT_MAX_C) ? 32'hFFFF_FFFF : 32'(ce);
	endfunction

	// registers
	state_t                state_q, state_d;
	in_word_t              item_q;
	logic [9:0]            r_q;
	logic [3:0]            mod_k_q;
	logic [AW-1:0]         clr_q;
	logic [SW-1:0]         idx_q;
	logic [COUNT_BITS-1:0] min_q;
	logic [SW-1:0]         vic_idx_q;
	logic                  vic_exact_q, vic_sign_q;
	logic                  res_found_q;
	logic [31:0]           res_count_q;
	logic                  out_valid_q;
	out_word_t             out_word_q;

	// RAM ports
	logic          meta_we, key_we, wave_we;
	logic [AW-1:0] meta_wa, meta_ra;
	logic [MW-1:0] meta_wd, meta_rd;
	logic [63:0]   key_rd;
	logic [RW-1:0] wave_wa;
	logic [31:0]   wave_wd, wave_rd;

	// row and slot addressing
	logic [RW-1:0] row;
	logic [AW-1:0] base;
	assign row  = RW'(r_q);
	assign base = AW'(32'(row) * 32'(SLOTS_PER_ROW));

	// slot read fields
	logic [COUNT_BITS-1:0] rd_count;
	logic                  rd_exact, rd_sign, rd_occ, rd_match, last_slot;
	assign rd_count  = meta_rd[MW-1:2];
	assign rd_exact  = meta_rd[1];
	assign rd_sign   = meta_rd[0];
	assign rd_occ    = (rd_count != '0);
	assign rd_match  = rd_occ && (key_rd == item_q.flow_key);
	assign last_slot = (idx_q == LAST_IDX);

	// row reduction step
	logic [26:0] mod_sub;
	assign mod_sub = 27'(ROWS) << mod_k_q;

	// replacement and waving update
	logic signed [33:0] wave_x, fi, add_v, wave_sum;
	logic               repl_ok;
	logic [CMPW-1:0]    vic_cnt_x;
	logic [31:0]        wave_new;
	always_comb begin
		wave_x    = 34'(signed'(wave_rd));
		fi        = item_q.key_sign ? wave_x : -wave_x;
		vic_cnt_x = CMPW'(min_q);
		repl_ok   = !fi[33] && (CMPW'(fi[32:0]) >= vic_cnt_x);
		if (!repl_ok) begin
			add_v    = 34'sd1;
			wave_sum = item_q.key_sign ? wave_x + add_v : wave_x - add_v;
		end else begin
			if (vic_exact_q) begin
				add_v = (vic_cnt_x > HALF_C) ? 34'sh0_8000_0000 : 34'(vic_cnt_x);
			end else begin
				add_v = 34'sd1;
			end
			wave_sum = vic_sign_q ? wave_x + add_v : wave_x - add_v;
		end
		if (wave_sum > 34'sh0_7FFF_FFFF) begin
			wave_new = 32'h7FFF_FFFF;
		end else if (wave_sum < -34'sh0_8000_0000) begin
			wave_new = 32'h8000_0000;
		end else begin
			wave_new = wave_sum[31:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR: begin
				if (32'(clr_q) == NSLOTS - 1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_ch.valid) state_d = NEED_MOD ? ST_MOD : ST_START;
			end
			ST_MOD: begin
				if (mod_k_q == 4'd0) state_d = ST_START;
			end
			ST_START: state_d = ST_SCAN;
			ST_SCAN: begin
				priority if (rd_match) state_d = ST_DONE;
				else if (!rd_occ && item_q.action == ACT_INSERT) state_d = ST_DONE;
				else if (last_slot) begin
					state_d = (item_q.action == ACT_QUERY) ? ST_DONE : ST_DECIDE;
				end
				else state_d = ST_SCAN;
			end
			ST_DECIDE: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || out_ch.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_CLR;
		endcase
	end

	// RAM controls
	logic       res_load;
	logic       res_found_d;
	logic [31:0] res_count_d;
	always_comb begin
		meta_we     = 1'b0;
		key_we      = 1'b0;
		wave_we     = 1'b0;
		meta_wa     = base + AW'(idx_q);
		meta_wd     = '0;
		meta_ra     = base + AW'(idx_q) + 1'b1;
		wave_wa     = row;
		wave_wd     = wave_new;
		res_load    = 1'b0;
		res_found_d = 1'b0;
		res_count_d = '0;
		unique case (state_q)
			ST_CLR: begin
				meta_we = 1'b1;
				meta_wa = clr_q;
				wave_we = (32'(clr_q) < ROWS);
				wave_wa = RW'(clr_q);
				wave_wd = '0;
			end
			ST_START: meta_ra = base;
			ST_SCAN: begin
				priority if (rd_match) begin
					res_load    = 1'b1;
					res_found_d = 1'b1;
					res_count_d = out_cnt(cnt_inc(rd_count));
					if (item_q.action == ACT_INSERT) begin
						meta_we = 1'b1;
						meta_wd = {cnt_inc(rd_count), rd_exact, rd_sign};
					end
				end else if (!rd_occ && item_q.action == ACT_INSERT) begin
					meta_we     = 1'b1;
					key_we      = 1'b1;
					meta_wd     = {COUNT_BITS'(1), 1'b1, item_q.key_sign};
					res_load    = 1'b1;
					res_found_d = 1'b1;
					res_count_d = 32'd1;
				end else if (last_slot) begin
					res_load = 1'b1;
				end else begin
					res_load = 1'b0;
				end
				// a query hit reports the count unchanged
				if (rd_match && item_q.action == ACT_QUERY) begin
					res_count_d = out_cnt(rd_count);
				end
			end
			ST_DECIDE: begin
				wave_we  = 1'b1;
				meta_wa  = base + AW'(vic_idx_q);
				res_load = 1'b1;
				if (repl_ok) begin
					meta_we     = 1'b1;
					key_we      = 1'b1;
					meta_wd     = {cnt_inc(min_q), 1'b0, item_q.key_sign};
					res_found_d = 1'b1;
					res_count_d = out_cnt(cnt_inc(min_q));
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_DONE && (!out_valid_q || out_ch.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					item_q  <= in_ch.data;
					r_q     <= in_ch.data.bucket_row;
					mod_k_q <= 4'd9;
				end
			end
			ST_MOD: begin
				if ({17'b0, r_q} >= mod_sub) r_q <= r_q - mod_sub[9:0];
				mod_k_q <= mod_k_q - 1'b1;
			end
			ST_START: begin
				idx_q <= '0;
				min_q <= '1;
			end
			ST_SCAN: begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == '0 || rd_count < min_q) begin
					min_q       <= rd_count;
					vic_idx_q   <= idx_q;
					vic_exact_q <= rd_exact;
					vic_sign_q  <= rd_sign;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ch.ready) begin
					out_word_q.found      <= res_found_q;
					out_word_q.flow_count <= res_count_q;
				end
			end
			default: ;
		endcase
		if (res_load) begin
			res_found_q <= res_found_d;
			res_count_q <= res_count_d;
		end
	end

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_word_q;

	// slot metadata {count, exact, sign}
	wstc_ram #(.WIDTH(MW), .DEPTH(NSLOTS)) u_meta (
		.clk(clk), .we(meta_we), .waddr(meta_wa), .wdata(meta_wd),
		.raddr(meta_ra), .rdata(meta_rd)
	);

	// slot keys, no clearing
	wstc_ram #(.WIDTH(64), .DEPTH(NSLOTS)) u_key (
		.clk(clk), .we(key_we), .waddr(meta_wa), .wdata(item_q.flow_key),
		.raddr(meta_ra), .rdata(key_rd)
	);

	// waving counters
	wstc_ram #(.WIDTH(32), .DEPTH(ROWS)) u_wave (
		.clk(clk), .we(wave_we), .waddr(wave_wa), .wdata(wave_wd),
		.raddr(row), .rdata(wave_rd)
	);

	`WSTC_ASSERT_NEXT(a_accept_leaves_idle, in_ch.valid && in_ch.ready, state_q != ST_IDLE)
	`WSTC_ASSERT_NOW(a_no_accept_in_clear, state_q == ST_CLR, !in_ch.ready)
	`WSTC_ASSERT_NOW(a_scan_index_range, state_q == ST_SCAN, 32'(idx_q) < SLOTS_PER_ROW)
	`WSTC_ASSERT_NOW(a_key_write_with_meta, key_we, meta_we)
endmodule

`default_nettype wire

/* rtl/core/wstc_ram.sv */
// ----------------------------------------------------------------------------
// wstc_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module wstc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

`default_nettype wire
